// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers clocked on clk; GRM_ASSERT is disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked only out of reset
`define GRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every edge, reset included
`define GRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GRM_ASSERT(lbl, prop, msg)
`define GRM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// widths, reset values and types of the gravity removal motion magnitude unit
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int AXIS_W    = 16;
  localparam int ALPHA_W   = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd131;
  localparam int LIN_MAG_W = 21;
  localparam int ROT_MAG_W = 16;

  // digit-by-digit square root: remainder and partial root
  localparam int ROOT_W = 21;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RAD_W  = 2 * ROOT_W;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_t;

endpackage

// ===== hdl/grm_in_if.sv =====
// ----------------------------------------------------------------------------
// grm_in_if
// request channel carrying one raw six-axis sample
// ----------------------------------------------------------------------------
interface grm_in_if;

  logic                               valid;
  logic                               ready;
  logic signed [grm_pkg::AXIS_W-1:0]  accel_x;
  logic signed [grm_pkg::AXIS_W-1:0]  accel_y;
  logic signed [grm_pkg::AXIS_W-1:0]  accel_z;
  logic signed [grm_pkg::AXIS_W-1:0]  gyro_x;
  logic signed [grm_pkg::AXIS_W-1:0]  gyro_y;
  logic signed [grm_pkg::AXIS_W-1:0]  gyro_z;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    input  ready
  );

  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    output ready
  );

endinterface

// ===== hdl/grm_out_if.sv =====
// ----------------------------------------------------------------------------
// grm_out_if
// result channel carrying the two motion magnitudes
// ----------------------------------------------------------------------------
interface grm_out_if;

  logic                                valid;
  logic                                ready;
  logic [grm_pkg::LIN_MAG_W-1:0]       linear_accel_magnitude;
  logic [grm_pkg::ROT_MAG_W-1:0]       rotation_magnitude;

  modport source (
    output valid, linear_accel_magnitude, rotation_magnitude,
    input  ready
  );

  modport sink (
    input  valid, linear_accel_magnitude, rotation_magnitude,
    output ready
  );

endinterface

// ===== hdl/gravity_removal_motion_magnitude_unit.sv =====
// ----------------------------------------------------------------------------
// gravity_removal_motion_magnitude_unit
// gravity-removed acceleration magnitude and rotation magnitude per sample
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one raw sample (three accelerometer and three gyroscope axes)
//   by valid/ready. The block tracks gravity per accelerometer axis with an
//   exponential average weighted by gravity_alpha, removes it and returns on
//   out_ch the floor square root of the squared linear acceleration (1/16 LSB)
//   and of the squared gyroscope vector (LSB).
//   cfg_wr_en/cfg_wr_data write gravity_alpha (Q0.16); the user must write it
//   only while the block is idle, as the block itself does not enforce this.
//   The next request is taken once the last result is in the output register.
//   One shared multiplier steps through three gravity updates and six squares,
//   then a 21-step square root loop works both magnitudes side by side.
//   Reset clears the gravity estimates to zero and sets gravity_alpha to 131.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next sample is already worked on, and the block waits only when
//   a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module gravity_removal_motion_magnitude_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [grm_pkg::ALPHA_W-1:0]   cfg_wr_data,
  grm_in_if.sink                        in_ch,
  grm_out_if.source                     out_ch
);

  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULA = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_SQA  = 4'd3;
  localparam logic [3:0] S_ACCA = 4'd4;
  localparam logic [3:0] S_SQG  = 4'd5;
  localparam logic [3:0] S_ACCG = 4'd6;
  localparam logic [3:0] S_ROOT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam int          AW        = grm_pkg::AXIS_W;
  localparam int          RW        = grm_pkg::ROOT_W;
  localparam int          RADW      = grm_pkg::RAD_W;
  localparam logic [1:0]  AX_LAST   = 2'd2;
  localparam logic [4:0]  STEP_LAST = 5'(RW - 1);

  // control
  logic [3:0]  state_r, state_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        load_out;

  // configuration and state
  logic [grm_pkg::ALPHA_W-1:0] alpha_r;
  logic signed [31:0]          grav_r [3];

  // sample and datapath
  logic signed [AW-1:0]  accel_r [3];
  logic signed [AW-1:0]  gyro_r  [3];
  logic signed [53:0]    prod_r;
  logic signed [20:0]    lin_r;
  logic [RADW-1:0]       acc_op_r, gyr_op_r;
  grm_pkg::root_t        acc_rt_r, gyr_rt_r;
  logic [grm_pkg::LIN_MAG_W-1:0] lin_mag_r;
  logic [grm_pkg::ROT_MAG_W-1:0] rot_mag_r;

  logic signed [AW-1:0]  sel_accel, sel_gyro;
  logic signed [31:0]    sel_grav, samp_q, grav_new;
  logic signed [32:0]    diff, lin_full;
  logic signed [32:0]    mul_a;
  logic signed [20:0]    mul_b;
  grm_pkg::root_t        acc_rt_nxt, gyr_rt_nxt;

  function automatic grm_pkg::root_t root_step(input grm_pkg::root_t cur,
                                               input logic [1:0] pair);
    logic [grm_pkg::REM_W+1:0] rem2;
    logic [grm_pkg::REM_W+1:0] trial;
    grm_pkg::root_t            res;
    rem2  = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (rem2 >= trial) begin
      res.rem  = grm_pkg::REM_W'(rem2 - trial);
      res.root = {cur.root[RW-2:0], 1'b1};
    end else begin
      res.rem  = grm_pkg::REM_W'(rem2);
      res.root = {cur.root[RW-2:0], 1'b0};
    end
    return res;
  endfunction

  always_comb begin
    unique case (ax_r)
      2'd0: begin
        sel_accel = accel_r[0];
        sel_gyro  = gyro_r[0];
        sel_grav  = grav_r[0];
      end
      2'd1: begin
        sel_accel = accel_r[1];
        sel_gyro  = gyro_r[1];
        sel_grav  = grav_r[1];
      end
      2'd2: begin
        sel_accel = accel_r[2];
        sel_gyro  = gyro_r[2];
        sel_grav  = grav_r[2];
      end
      default: begin
        sel_accel = '0;
        sel_gyro  = '0;
        sel_grav  = '0;
      end
    endcase
  end

  assign samp_q   = {sel_accel, 16'h0000};
  assign diff     = {samp_q[31], samp_q} - {sel_grav[31], sel_grav};
  // product is alpha * diff; its arithmetic shift by 16 can exceed 32 bits, but its sum with sel_grav always fits
  assign grav_new = sel_grav + prod_r[47:16];
  assign lin_full = {samp_q[31], samp_q} - {grav_new[31], grav_new};

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      S_MULA: begin
        mul_a = diff;
        mul_b = {5'd0, alpha_r};
      end
      S_SQA: begin
        mul_a = {{12{lin_r[20]}}, lin_r};
        mul_b = lin_r;
      end
      S_SQG: begin
        mul_a = {{17{sel_gyro[AW-1]}}, sel_gyro};
        mul_b = {{5{sel_gyro[AW-1]}}, sel_gyro};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_rt_nxt = root_step(acc_rt_r, acc_op_r[RADW-1:RADW-2]);
  assign gyr_rt_nxt = root_step(gyr_rt_r, gyr_op_r[RADW-1:RADW-2]);

  assign in_ch.ready = (state_r == S_IDLE);
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_MULA;
          ax_nxt    = 2'd0;
        end
      end
      S_MULA: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_SQA;
      S_SQA:  state_nxt = S_ACCA;
      S_ACCA: begin
        if (ax_r == AX_LAST) begin
          state_nxt = S_SQG;
          ax_nxt    = 2'd0;
        end else begin
          state_nxt = S_MULA;
          ax_nxt    = ax_r + 2'd1;
        end
      end
      S_SQG:  state_nxt = S_ACCG;
      S_ACCG: begin
        if (ax_r == AX_LAST) begin
          state_nxt = S_ROOT;
          cnt_nxt   = '0;
        end else begin
          state_nxt = S_SQG;
          ax_nxt    = ax_r + 2'd1;
        end
      end
      S_ROOT: begin
        if (cnt_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= grm_pkg::ALPHA_RST;
      grav_r[0]   <= '0;
      grav_r[1]   <= '0;
      grav_r[2]   <= '0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
      if (state_r == S_UPD) begin
        grav_r[ax_r] <= grav_new;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      accel_r[0] <= in_ch.accel_x;
      accel_r[1] <= in_ch.accel_y;
      accel_r[2] <= in_ch.accel_z;
      gyro_r[0]  <= in_ch.gyro_x;
      gyro_r[1]  <= in_ch.gyro_y;
      gyro_r[2]  <= in_ch.gyro_z;
      acc_op_r   <= '0;
      gyr_op_r   <= '0;
    end
    prod_r <= mul_a * mul_b;
    if (state_r == S_UPD) begin
      // floor shift by 12 to q.4
      lin_r <= lin_full[32:12];
    end
    if (state_r == S_ACCA) begin
      acc_op_r <= acc_op_r + prod_r[RADW-1:0];
    end
    if (state_r == S_ACCG) begin
      gyr_op_r <= gyr_op_r + prod_r[RADW-1:0];
      acc_rt_r <= '0;
      gyr_rt_r <= '0;
    end
    if (state_r == S_ROOT) begin
      acc_rt_r <= acc_rt_nxt;
      gyr_rt_r <= gyr_rt_nxt;
      acc_op_r <= {acc_op_r[RADW-3:0], 2'b00};
      gyr_op_r <= {gyr_op_r[RADW-3:0], 2'b00};
    end
    if (load_out) begin
      lin_mag_r <= acc_rt_r.root;
      rot_mag_r <= gyr_rt_r.root[grm_pkg::ROT_MAG_W-1:0];
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.linear_accel_magnitude = lin_mag_r;
  assign out_ch.rotation_magnitude     = rot_mag_r;

  `GRM_ASSERT(a_root_ends, (state_r == S_ROOT && cnt_r == STEP_LAST) |=> state_r == S_DONE, "root loop overran")
  `GRM_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r) == S_DONE, "result raised outside done")
  `GRM_ASSERT(a_gyro_sum_range, (state_r == S_ROOT && cnt_r == 5'd0) |-> gyr_op_r[RADW-1:33] == '0, "gyro square sum out of range")
  `GRM_ASSERT(a_alpha_zero_hold, (state_r == S_UPD && alpha_r == '0) |=> ($stable(grav_r[0]) && $stable(grav_r[1]) && $stable(grav_r[2])), "gravity moved with zero alpha")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gravity removal motion magnitude unit: samples
// go in through a queue-fed driver, a clocked monitor takes the magnitudes and
// compares them in order against a bit-true model of the gravity tracking and
// both square roots, across several gravity_alpha settings
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AT     = 400;   // requests taken before the long hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 120;

  typedef logic signed [grm_pkg::AXIS_W-1:0] axis_t;

  typedef struct packed {
    axis_t accel_x;
    axis_t accel_y;
    axis_t accel_z;
    axis_t gyro_x;
    axis_t gyro_y;
    axis_t gyro_z;
  } imu_sample_t;

  typedef struct packed {
    logic [grm_pkg::LIN_MAG_W-1:0] linear;
    logic [grm_pkg::ROT_MAG_W-1:0] rotation;
  } motion_mag_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        cfg_wr_en   = 1'b0;
  logic [grm_pkg::ALPHA_W-1:0] cfg_wr_data = '0;

  logic        req_valid  = 1'b0;
  imu_sample_t req_sample = '0;
  logic        rsp_ready  = 1'b0;

  grm_in_if  in_ch ();
  grm_out_if out_ch ();

  assign in_ch.valid   = req_valid;
  assign in_ch.accel_x = req_sample.accel_x;
  assign in_ch.accel_y = req_sample.accel_y;
  assign in_ch.accel_z = req_sample.accel_z;
  assign in_ch.gyro_x  = req_sample.gyro_x;
  assign in_ch.gyro_y  = req_sample.gyro_y;
  assign in_ch.gyro_z  = req_sample.gyro_z;
  assign out_ch.ready  = rsp_ready;

  gravity_removal_motion_magnitude_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk = ~clk;

  // model state
  logic [grm_pkg::ALPHA_W-1:0] alpha_q016 = grm_pkg::ALPHA_RST;
  logic signed [31:0] gravity_est [3] = '{32'sd0, 32'sd0, 32'sd0};

  imu_sample_t pending_samples [$];
  motion_mag_t pending_magnitudes [$];

  int   n_accepted = 0;
  int   n_checked  = 0;
  int   n_errors   = 0;
  int   n_settings = 1;
  int   cycle_count = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;
  logic calm       = 1'b0;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // advances the gravity estimates by one sample and returns both magnitudes
  function automatic motion_mag_t predict_magnitudes(imu_sample_t smp);
    longint          acc_raw [3];
    longint          gyr_raw [3];
    longint          smp_q;
    longint          g;
    longint          lin;
    longint unsigned m;
    longint unsigned acc_sum;
    longint unsigned gyr_sum;
    longint unsigned root;
    motion_mag_t     res;
    acc_raw[0] = smp.accel_x;
    acc_raw[1] = smp.accel_y;
    acc_raw[2] = smp.accel_z;
    gyr_raw[0] = smp.gyro_x;
    gyr_raw[1] = smp.gyro_y;
    gyr_raw[2] = smp.gyro_z;
    acc_sum = 0;
    gyr_sum = 0;
    for (int i = 0; i < 3; i++) begin
      smp_q = acc_raw[i] * 65536;
      g     = gravity_est[i];
      // arithmetic shifts floor towards minus infinity
      g     = g + ((longint'(alpha_q016) * (smp_q - g)) >>> 16);
      gravity_est[i] = g[31:0];
      lin   = (smp_q - g) >>> 12;
      m     = (lin < 0) ? -lin : lin;
      acc_sum += m * m;
      m     = (gyr_raw[i] < 0) ? -gyr_raw[i] : gyr_raw[i];
      gyr_sum += m * m;
    end
    root         = floor_root(acc_sum);
    res.linear   = root[grm_pkg::LIN_MAG_W-1:0];
    root         = floor_root(gyr_sum);
    res.rotation = root[grm_pkg::ROT_MAG_W-1:0];
    return res;
  endfunction

  function automatic axis_t jitter(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return axis_t'(v);
  endfunction

  function automatic axis_t extreme_value();
    case ($urandom_range(0, 6))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && in_ch.ready) begin
        pending_magnitudes.push_back(predict_magnitudes(req_sample));
        n_accepted <= n_accepted + 1;
      end
      if (!req_valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          req_sample <= pending_samples.pop_front();
          req_valid  <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    motion_mag_t want;
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rsp_ready) begin
        if (pending_magnitudes.size() == 0) begin
          $display("%0t: unexpected result: linear %0d rotation %0d", $time,
                   out_ch.linear_accel_magnitude, out_ch.rotation_magnitude);
          n_errors++;
        end else begin
          want = pending_magnitudes.pop_front();
          n_checked++;
          if (out_ch.linear_accel_magnitude !== want.linear) begin
            $display("%0t: linear_accel_magnitude expected %0d got %0d", $time,
                     want.linear, out_ch.linear_accel_magnitude);
            n_errors++;
          end
          if (out_ch.rotation_magnitude !== want.rotation) begin
            $display("%0t: rotation_magnitude expected %0d got %0d", $time,
                     want.rotation, out_ch.rotation_magnitude);
            n_errors++;
          end
        end
      end
      rsp_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_magnitudes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_sample(int ax, int ay, int az, int gx, int gy, int gz);
    imu_sample_t smp;
    smp = '{axis_t'(ax), axis_t'(ay), axis_t'(az),
            axis_t'(gx), axis_t'(gy), axis_t'(gz)};
    pending_samples.push_back(smp);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || req_valid || pending_magnitudes.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_alpha(logic [grm_pkg::ALPHA_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    alpha_q016   = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int          centre [3];
    int          spread;
    int          k;
    imu_sample_t smp;
    logic [grm_pkg::ALPHA_W-1:0] phase_alpha [8];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficient: extremes, sign handling and alternating bit patterns
    push_sample(0, 0, 0, 0, 0, 0);
    push_sample(32767, 32767, 32767, 32767, 32767, 32767);
    push_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    push_sample(32767, -32768, 0, -32768, 32767, 1);
    push_sample(-1, 1, -1, -1, 1, -1);
    push_sample(21845, -21846, 21845, 21845, -21846, 21845);
    push_sample(-21846, 21845, -21846, -21846, 21845, -21846);

    // near-unity coefficient drags the estimates down to the negative rail
    write_alpha(16'hFFFF);
    push_sample(32767, 32767, 32767, 0, 0, 0);
    push_sample(-32768, -32768, -32768, 0, 0, 0);
    push_sample(-32768, -32768, -32768, 0, 0, 0);
    push_sample(-32768, -32768, -32768, 0, 0, 0);

    // frozen estimate: opposite rail gives the largest linear magnitude
    write_alpha(16'h0000);
    push_sample(32767, 32767, 32767, -32768, -32768, -32768);
    push_sample(-32768, -32768, -32768, 32767, -32768, 32767);
    push_sample(0, 0, 0, 0, 0, 0);

    phase_alpha = '{16'd1, grm_pkg::ALPHA_RST, 16'd0, 16'hFFFF, 16'h8000,
                    grm_pkg::ALPHA_W'($urandom()),
                    grm_pkg::ALPHA_W'($urandom_range(0, 1023)),
                    grm_pkg::ALPHA_W'($urandom())};

    for (int p = 0; p < 8; p++) begin
      write_alpha(phase_alpha[p]);
      calm = (p == 1);
      for (int a = 0; a < 3; a++) centre[a] = int'($urandom_range(0, 40000)) - 20000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        k = $urandom_range(0, 99);
        // sensor turned over now and then
        if ($urandom_range(0, 49) == 0)
          for (int a = 0; a < 3; a++) centre[a] = int'($urandom_range(0, 40000)) - 20000;
        if (k < 80) begin
          spread = ($urandom_range(0, 9) == 0) ? 8000 : 300;
          smp.accel_x = jitter(centre[0], spread);
          smp.accel_y = jitter(centre[1], spread);
          smp.accel_z = jitter(centre[2], spread);
          spread = ($urandom_range(0, 3) == 0) ? 32767 : 200;
          smp.gyro_x  = jitter(0, spread);
          smp.gyro_y  = jitter(0, spread);
          smp.gyro_z  = jitter(0, spread);
        end else if (k < 90) begin
          smp = imu_sample_t'({$urandom(), $urandom(), $urandom()});
        end else begin
          smp = '{extreme_value(), extreme_value(), extreme_value(),
                  extreme_value(), extreme_value(), extreme_value()};
        end
        pending_samples.push_back(smp);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("checked %0d samples over %0d gravity_alpha settings, %0d mismatches",
             n_checked, n_settings, n_errors);
    $display("receiver held off for %0d cycles once with requests still offered",
             HOLD_CYCLES);
    if (n_errors == 0 && pending_magnitudes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/grm_pkg.sv
hdl/grm_in_if.sv
hdl/grm_out_if.sv
hdl/gravity_removal_motion_magnitude_unit.sv
tb/sv/tb_top.sv
